@@ design/iougt_pkg.sv @@
// Package for the greedy IoU tracker: controller/datapath command and status types.
// No dependencies.
`default_nettype none
package iougt_pkg;
  typedef struct packed {
    logic load;       // latch detection, start scan
    logic eval;       // evaluate current slot
    logic commit;     // apply match or allocation
    logic age;        // age current slot
    logic clr_first;  // clear the first-frame flag
    logic out_load;   // register result
  } iougt_cmd_t;

  typedef struct packed {
    logic last_slot;  // slot counter at final slot
    logic last_flag;  // latched last_in_frame
  } iougt_sts_t;
endpackage
`default_nettype wire

@@ design/iougt_datapath.sv @@
// Datapath of the IoU tracker: slot store, IoU scan unit, aging sweep, result register.
// Depends on iougt_pkg.
`default_nettype none
module iougt_datapath #(
  parameter int MAX_TRACKS = 32,
  parameter int COORD_BITS = 12,
  parameter int ID_BITS    = 16
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  iougt_pkg::iougt_cmd_t    cmd,
  output iougt_pkg::iougt_sts_t    sts,
  input  wire  [7:0]               thr,
  input  wire  [7:0]               lost_limit,
  input  wire  [7:0]               d_class,
  input  wire  [COORD_BITS-1:0]    d_x,
  input  wire  [COORD_BITS-1:0]    d_y,
  input  wire  [COORD_BITS-1:0]    d_w,
  input  wire  [COORD_BITS-1:0]    d_h,
  input  wire                      d_last,
  output logic [15:0]              r_id,
  output logic                     r_new,
  output logic                     r_full
);
  import iougt_pkg::*;

  localparam int SW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int EW = COORD_BITS + 1;
  localparam int AW = 2 * EW;
  localparam int PW = 2 * AW + 1;

  // Slot store; small enough for flip-flops, each entry read at the scan index.
  logic [MAX_TRACKS-1:0] valid_r, seen_r;
  logic [7:0]            cls_r  [MAX_TRACKS];
  logic [COORD_BITS-1:0] bx_r   [MAX_TRACKS];
  logic [COORD_BITS-1:0] by_r   [MAX_TRACKS];
  logic [COORD_BITS-1:0] bw_r   [MAX_TRACKS];
  logic [COORD_BITS-1:0] bh_r   [MAX_TRACKS];
  logic [ID_BITS-1:0]    tid_r  [MAX_TRACKS];
  logic [7:0]            miss_r [MAX_TRACKS];
  logic [ID_BITS-1:0]    next_id_r;
  logic                  first_r;

  // Latched detection and scan state.
  logic [7:0]            dc_r;
  logic [COORD_BITS-1:0] dx_r, dy_r, dw_r, dh_r;
  logic                  dl_r;
  logic [SW-1:0]         idx_r;
  logic                  found_r;
  logic [SW-1:0]         best_r;
  logic [AW-1:0]         bi_r, bu_r;

  // Overlap of one slot, registered ahead of the best-so-far compare.
  logic                  ev_r;
  logic                  hit_r;
  logic [SW-1:0]         ps_r;
  logic [AW-1:0]         inter_r, uni_r;

  assign sts.last_slot = (idx_r == SW'(MAX_TRACKS - 1));
  assign sts.last_flag = dl_r;

  // Overlap of the current slot with the detection.
  logic [EW-1:0] x0, x1, y0, y1, ax1, bx1, ay1, by1;
  logic [AW-1:0] inter, sa, da, uni;
  logic          hit;
  always_comb begin
    x0  = (bx_r[idx_r] > dx_r) ? EW'(bx_r[idx_r]) : EW'(dx_r);
    y0  = (by_r[idx_r] > dy_r) ? EW'(by_r[idx_r]) : EW'(dy_r);
    ax1 = EW'(bx_r[idx_r]) + EW'(bw_r[idx_r]);
    bx1 = EW'(dx_r) + EW'(dw_r);
    ay1 = EW'(by_r[idx_r]) + EW'(bh_r[idx_r]);
    by1 = EW'(dy_r) + EW'(dh_r);
    x1  = (ax1 < bx1) ? ax1 : bx1;
    y1  = (ay1 < by1) ? ay1 : by1;
    inter = ((x0 < x1) && (y0 < y1)) ? AW'(x1 - x0) * AW'(y1 - y0) : '0;
    sa  = AW'(bw_r[idx_r]) * AW'(bh_r[idx_r]);
    da  = AW'(dw_r) * AW'(dh_r);
    uni = AW'((PW'(sa) + PW'(da)) - PW'(inter));
    hit = valid_r[idx_r] && (cls_r[idx_r] == dc_r) && (uni != '0) && (inter != '0)
          && !first_r;
  end

  // Cross products for the best-so-far compare (registered inputs, products used once).
  logic [PW-1:0] p1, p2, q1, q2;
  logic          better, match;
  always_comb begin
    p1 = PW'(inter_r) * PW'(bu_r);
    p2 = PW'(bi_r) * PW'(uni_r);
    better = !found_r || (p1 > p2);
    q1 = PW'({bi_r, 8'd0});
    q2 = PW'(thr) * PW'(bu_r);
    match = found_r && (q1 > q2);
  end

  // Lowest free slot.
  logic          free_ok;
  logic [SW-1:0] free_s;
  always_comb begin
    free_ok = 1'b0;
    free_s  = '0;
    for (int s = MAX_TRACKS - 1; s >= 0; s--) begin
      if (!valid_r[s]) begin
        free_ok = 1'b1;
        free_s  = SW'(s);
      end
    end
  end

  logic [7:0] miss_nxt;
  always_comb begin
    if (seen_r[idx_r]) miss_nxt = '0;
    else if (miss_r[idx_r] != 8'hFF) miss_nxt = miss_r[idx_r] + 8'd1;
    else miss_nxt = miss_r[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      seen_r    <= '0;
      next_id_r <= '0;
      first_r   <= 1'b1;
      idx_r     <= '0;
      found_r   <= 1'b0;
      ev_r      <= 1'b0;
    end else begin
      ev_r <= cmd.eval;
      // Latch a new detection and restart the scan.
      if (cmd.load) begin
        dc_r <= d_class; dx_r <= d_x; dy_r <= d_y; dw_r <= d_w; dh_r <= d_h;
        dl_r <= d_last;
        idx_r <= '0;
        found_r <= 1'b0;
      end
      // One slot of the IoU scan: overlap areas are registered first.
      if (cmd.eval) begin
        hit_r   <= hit;
        inter_r <= inter;
        uni_r   <= uni;
        ps_r    <= idx_r;
        idx_r <= idx_r + SW'(1);
      end
      // Best-so-far update in the cycle after the overlap is registered.
      if (ev_r) begin
        if (hit_r && better) begin
          found_r <= 1'b1;
          best_r  <= ps_r;
          bi_r    <= inter_r;
          bu_r    <= uni_r;
        end
      end
      // Match or allocation.
      if (cmd.commit) begin
        idx_r <= '0;
        if (match) begin
          bx_r[best_r] <= dx_r; by_r[best_r] <= dy_r;
          bw_r[best_r] <= dw_r; bh_r[best_r] <= dh_r;
          seen_r[best_r] <= 1'b1;
          r_id <= 16'(tid_r[best_r]); r_new <= 1'b0; r_full <= 1'b0;
        end else if (free_ok) begin
          valid_r[free_s] <= 1'b1;
          seen_r[free_s]  <= 1'b1;
          cls_r[free_s]   <= dc_r;
          bx_r[free_s] <= dx_r; by_r[free_s] <= dy_r;
          bw_r[free_s] <= dw_r; bh_r[free_s] <= dh_r;
          tid_r[free_s]  <= next_id_r;
          miss_r[free_s] <= '0;
          r_id <= 16'(next_id_r); r_new <= 1'b1; r_full <= 1'b0;
          next_id_r <= next_id_r + ID_BITS'(1);
        end else begin
          r_id <= '0; r_new <= 1'b0; r_full <= 1'b1;
        end
      end
      // One slot of the frame-end aging sweep.
      if (cmd.age) begin
        if (valid_r[idx_r]) begin
          miss_r[idx_r] <= miss_nxt;
          if (miss_nxt > lost_limit) valid_r[idx_r] <= 1'b0;
        end
        seen_r[idx_r] <= 1'b0;
        idx_r <= idx_r + SW'(1);
      end
      if (cmd.clr_first) first_r <= 1'b0;
    end
  end

  // A slot is never seen without being valid outside the aging sweep.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> ((seen_r & ~valid_r) == '0))
    else $error("seen bit set on invalid slot");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && !match && free_ok |=> valid_r[$past(free_s)])
    else $error("allocated slot not valid");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> !(r_new && r_full))
    else $error("new and full together");
endmodule
`default_nettype wire

@@ design/iougt_ctrl.sv @@
// Controller of the IoU tracker: sequences scan, commit, aging and the output handshake.
// Depends on iougt_pkg.
`default_nettype none
module iougt_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire                    out_ready,
  output iougt_pkg::iougt_cmd_t  cmd,
  input  iougt_pkg::iougt_sts_t  sts
);
  import iougt_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_COMMIT, S_AGE} state_t;
  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  // The next item may enter once the previous result has been taken and the scan is idle.
  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    ov_nxt = ov_r && !out_ready;
    case (state_r)
      S_IDLE: if (in_valid && in_ready) begin
        cmd.load = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.eval = 1'b1;
        if (sts.last_slot) state_nxt = S_DRAIN;
      end
      // The compare of the last slot lands in this cycle.
      S_DRAIN: state_nxt = S_COMMIT;
      S_COMMIT: begin
        cmd.commit = 1'b1;
        ov_nxt = 1'b1;
        state_nxt = sts.last_flag ? S_AGE : S_IDLE;
      end
      S_AGE: begin
        cmd.age = 1'b1;
        if (sts.last_slot) begin
          cmd.clr_first = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid) else $error("result not presented after commit");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !in_ready) else $error("request taken during scan");
endmodule
`default_nettype wire

@@ design/iou_greedy_object_tracker.sv @@
// Top level of the greedy IoU tracker: stream ports, APB registers, controller and datapath.
// Depends on iougt_pkg, iougt_ctrl, iougt_datapath.
//
//  channel | direction | payload
//  in_     | slave     | class, box, last_in_frame
//  out_    | master    | track id, is_new, table_full
//  cfg_    | APB       | match_threshold @0, lost_limit @4
//
// A request passes through load, one overlap per slot, the last compare, commit and the result
// handshake from acceptance to the next acceptance; the result is registered at commit. The
// request ending a frame adds an aging sweep over all slots, which hides the result handshake.
// The slot scan sets the rate. Reset is synchronous, active low, and clears all tracks at once.
// A held result blocks the next request only until out_tready takes it.
`default_nettype none
module iou_greedy_object_tracker #(
  parameter int MAX_TRACKS = 32,
  parameter int COORD_BITS = 12,
  parameter int ID_BITS    = 16
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  // tdata: class_label[7:0], box_x, box_y, box_width, box_height (COORD_BITS each)
  input  wire  [((8+4*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input  wire                    in_tlast,   // last_in_frame
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [15:0]            out_tdata,  // track id
  // tuser: is_new [0], table_full [1]
  output logic [1:0]             out_tuser,
  input  wire                    cfg_psel,
  input  wire                    cfg_penable,
  input  wire                    cfg_pwrite,
  input  wire  [2:0]             cfg_paddr,
  input  wire  [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);
  import iougt_pkg::*;

  localparam logic [2:0] ADDR_THR  = 3'd0;
  localparam logic [2:0] ADDR_LOST = 3'd4;
  localparam int CB = COORD_BITS;

  // Configuration registers.
  logic [7:0] thr_r, lost_r;
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= 8'd128;
      lost_r <= 8'd10;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr == ADDR_THR) thr_r <= cfg_pwdata[7:0];
      else if (cfg_paddr == ADDR_LOST) lost_r <= cfg_pwdata[7:0];
    end
  end
  always_comb begin
    case (cfg_paddr)
      ADDR_THR:  cfg_prdata = {24'd0, thr_r};
      ADDR_LOST: cfg_prdata = {24'd0, lost_r};
      default:   cfg_prdata = '0;
    endcase
  end

  iougt_cmd_t cmd;
  iougt_sts_t sts;
  logic r_new, r_full;

  iougt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .cmd(cmd), .sts(sts)
  );

  iougt_datapath #(.MAX_TRACKS(MAX_TRACKS), .COORD_BITS(COORD_BITS), .ID_BITS(ID_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .thr(thr_r), .lost_limit(lost_r),
    .d_class(in_tdata[7:0]),
    .d_x(in_tdata[8 +: CB]), .d_y(in_tdata[8+CB +: CB]),
    .d_w(in_tdata[8+2*CB +: CB]), .d_h(in_tdata[8+3*CB +: CB]),
    .d_last(in_tlast),
    .r_id(out_tdata), .r_new(r_new), .r_full(r_full)
  );
  assign out_tuser = {r_full, r_new};
endmodule
`default_nettype wire
